/* hw/rtl/okvl_pkg.sv */
// Shared types and constants for the ordered key/value list.
`timescale 1ns / 1ps

package okvl_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned IN_DATA_W  = KEY_W + VAL_W;
  localparam int unsigned OUT_DATA_W = STAT_W + 1 + VAL_W + COUNT_W;

  // Bit pattern of the double -1.0, returned on a lookup miss.
  localparam logic [VAL_W-1:0] MISS_PATTERN = 64'hBFF0_0000_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DELETE    = 3'd2,
    OP_LOOKUP    = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_UPD
  } state_e;

  // Per-cell update command.
  typedef struct packed {
    logic take_left;   // shift toward the back
    logic take_right;  // shift toward the front
    logic load_new;    // write the incoming entry
  } cell_ctrl_t;

endpackage

/* hw/rtl/ordered_key_value_list.sv */
// Top level of the ordered key/value list: control, cell chain and result register.
`timescale 1ns / 1ps

// Bounded ordered list of key/value entries held in a row of CAPACITY cells, front
// at cell 0. Each accepted beat carries an operation in tuser (insert front, insert
// back, delete first match, lookup first match, clear) and returns one result beat.
// Each item passes through a compare cycle in which every cell matches its key and
// the hit vector is registered, then an update cycle in which the front-most hit is
// picked, the cells shift one place toward the back or front or load the first free
// slot as the operation needs, and the result is written to the output register. The
// next beat is accepted in that update cycle, not during a compare cycle; a stalled
// output holds the update cycle until the result register frees. Slot contents are
// undefined until written; only slots below the entry count are ever compared or
// read. No clearing pass runs after reset.
module ordered_key_value_list import okvl_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // key[31:0], value[95:32]
  input  logic [OP_W-1:0]       s_axis_tuser_i,   // operation[2:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // status[1:0], found[2],
                                                  // result_value[66:3], entry_count[71:67]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CAPACITY-1:0] hit_q;

  logic in_fire, out_free, upd_fire;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  cell_ctrl_t          cell_ctrl [CAPACITY];

  logic             sel_found;
  logic [VAL_W-1:0] sel_value;
  logic [CAPACITY-1:0] from_hit;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  status_e          res_status;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic [CntW+COUNT_W-1:0] count_ext;

  logic is_full, is_empty;
  logic do_front, do_back, do_delete;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign upd_fire        = (state_q == S_UPD) && out_free;
  assign s_axis_tready_o = (state_q == S_IDLE) || upd_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_EVAL;
      S_EVAL: state_d = S_UPD;
      S_UPD: begin
        if (out_free) state_d = in_fire ? S_EVAL : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[KEY_W-1:0];
      val_q <= s_axis_tdata_i[IN_DATA_W-1:KEY_W];
    end
    if (state_q == S_EVAL) begin
      hit_q <= cell_hit;
    end
  end

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Result and count for the item in the update cycle.
  always_comb begin
    res_status = STAT_OK;
    res_found  = 1'b0;
    res_value  = '0;
    count_d    = count_q;
    do_front   = 1'b0;
    do_back    = 1'b0;
    do_delete  = 1'b0;
    unique case (op_q)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (is_full) begin
          res_status = STAT_FULL;
        end else begin
          do_front = (op_q == OP_INS_FRONT);
          do_back  = (op_q == OP_INS_BACK);
          count_d  = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          res_status = STAT_EMPTY;
        end else if (!sel_found) begin
          res_status = STAT_NOT_FOUND;
        end else begin
          res_found = 1'b1;
          do_delete = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      OP_LOOKUP: begin
        res_value = MISS_PATTERN;
        if (is_empty) begin
          res_status = STAT_EMPTY;
        end else if (!sel_found) begin
          res_status = STAT_NOT_FOUND;
        end else begin
          res_found = 1'b1;
          res_value = sel_value;
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
    if (!upd_fire) begin
      count_d   = count_q;
      do_front  = 1'b0;
      do_back   = 1'b0;
      do_delete = 1'b0;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_d};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic [VAL_W-1:0] lv, rv;

    if (i == 0) begin : g_front
      assign lk = key_q;
      assign lv = val_q;
    end else begin : g_mid_l
      assign lk = cell_key[i-1];
      assign lv = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign rk = cell_key[i];
      assign rv = cell_val[i];
    end else begin : g_mid_r
      assign rk = cell_key[i+1];
      assign rv = cell_val[i+1];
    end

    assign cell_ctrl[i].take_left  = do_front;
    assign cell_ctrl[i].take_right = do_delete && from_hit[i];
    assign cell_ctrl[i].load_new   = do_back && (count_q == CntW'(i));

    okvl_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .occupied_i    (count_q > CntW'(i)),
      .cmp_key_i     (key_q),
      .new_key_i     (key_q),
      .new_value_i   (val_q),
      .left_key_i    (lk),
      .left_value_i  (lv),
      .right_key_i   (rk),
      .right_value_i (rv),
      .key_o         (cell_key[i]),
      .value_o       (cell_val[i]),
      .hit_o         (cell_hit[i])
    );
  end

  okvl_select #(
    .N (CAPACITY)
  ) u_select (
    .hit_i      (hit_q),
    .value_i    (cell_val),
    .found_o    (sel_found),
    .value_o    (sel_value),
    .from_hit_o (from_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (upd_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      m_data_q <= {count_ext[COUNT_W-1:0], res_value, res_found, res_status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* hw/rtl/okvl_cell.sv */
// One list slot: holds a key and a value, compares the key, moves data to neighbors.
`timescale 1ns / 1ps

module okvl_cell import okvl_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             occupied_i,
  input  logic [KEY_W-1:0] cmp_key_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [VAL_W-1:0] new_value_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [VAL_W-1:0] left_value_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [VAL_W-1:0] right_value_i,
  output logic [KEY_W-1:0] key_o,
  output logic [VAL_W-1:0] value_o,
  output logic             hit_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] value_q, value_d;

  always_comb begin
    priority if (ctrl_i.take_left) begin
      key_d   = left_key_i;
      value_d = left_value_i;
    end else if (ctrl_i.take_right) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end else if (ctrl_i.load_new) begin
      key_d   = new_key_i;
      value_d = new_value_i;
    end else begin
      key_d   = key_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign hit_o   = occupied_i && (key_q == cmp_key_i);

endmodule

/* hw/rtl/okvl_select.sv */
// Front-most hit priority: one-hot of first match, its value, and the shift region.
`timescale 1ns / 1ps

module okvl_select import okvl_pkg::*; #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0]     hit_i,
  input  logic [VAL_W-1:0] value_i [N],
  output logic             found_o,
  output logic [VAL_W-1:0] value_o,
  output logic [N-1:0]     from_hit_o   // cells at or behind the first hit
);

  function automatic logic [N-1:0] low_mask(input int unsigned n);
    logic [N-1:0] m;
    for (int unsigned j = 0; j < N; j++) begin
      m[j] = (j < n);
    end
    return m;
  endfunction

  logic [N-1:0] first;

  always_comb begin
    for (int unsigned i = 0; i < N; i++) begin
      first[i]      = hit_i[i] && !(|(hit_i & low_mask(i)));
      from_hit_o[i] = |(hit_i & low_mask(i + 1));
    end
  end

  always_comb begin
    value_o = '0;
    for (int unsigned i = 0; i < N; i++) begin
      value_o = value_o | (value_i[i] & {VAL_W{first[i]}});
    end
  end

  assign found_o = |hit_i;

endmodule

/* test/ordered_key_value_list_tb.sv */
// Self-checking testbench for the ordered key/value list: directed cases, then random traffic.
`timescale 1ns / 1ps

module ordered_key_value_list_tb;
  import okvl_pkg::*;

  localparam int unsigned CAPACITY = 16;
  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;   // key[31:0], value[95:32]
  logic [OP_W-1:0]       s_axis_tuser_i = '0;   // operation[2:0]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;        // status[1:0], found[2],
                                                // result_value[66:3], entry_count[71:67]

  // mirror of the list contents, front at index 0
  logic [KEY_W-1:0] mirror_keys [CAPACITY];
  logic [VAL_W-1:0] mirror_vals [CAPACITY];
  int unsigned      mirror_count = 0;

  list_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  ops_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  full_rejects = 0;
  int unsigned  key_hits = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;
  int           stall_left = 0;

  ordered_key_value_list #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Applies one operation to the mirror and returns the result the block must give.
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    int           hit;
    int           i;
    res = '{status: STAT_OK, found: 1'b0, value: '0, count: '0};
    hit = -1;
    for (i = 0; i < int'(mirror_count); i++)
      if (hit < 0 && mirror_keys[i] == key) hit = i;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (mirror_count >= CAPACITY) begin
          res.status = STAT_FULL;
          full_rejects++;
        end else if (op == OP_INS_FRONT) begin
          for (i = int'(mirror_count); i > 0; i--) begin
            mirror_keys[i] = mirror_keys[i-1];
            mirror_vals[i] = mirror_vals[i-1];
          end
          mirror_keys[0] = key;
          mirror_vals[0] = val;
          mirror_count++;
        end else begin
          mirror_keys[mirror_count] = key;
          mirror_vals[mirror_count] = val;
          mirror_count++;
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        if (op == OP_LOOKUP) res.value = MISS_PATTERN;
        if (mirror_count == 0) begin
          res.status = STAT_EMPTY;
        end else if (hit < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.found = 1'b1;
          key_hits++;
          if (op == OP_LOOKUP) begin
            res.value = mirror_vals[hit];
          end else begin
            // later entries move up one place
            for (i = hit; i + 1 < int'(mirror_count); i++) begin
              mirror_keys[i] = mirror_keys[i+1];
              mirror_vals[i] = mirror_vals[i+1];
            end
            mirror_count--;
          end
        end
      end
      OP_CLEAR: mirror_count = 0;
      default: ;
    endcase
    res.count = mirror_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Called in the step of the previous acceptance (or after a drain); returns in the
  // step where this beat is accepted.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {val, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_list_op(op, key, val));
    ops_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && mirror_count > 0) return mirror_keys[$urandom_range(0, mirror_count - 1)];
    if (r < 65) return KEY_MIN + $urandom_range(0, 2);
    if (r < 80) return KEY_MAX - $urandom_range(0, 2);
    if (r < 90) return $urandom_range(0, 5);
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_op(OP_LOOKUP, 32'd0, 64'd0);
    send_op(OP_DELETE, KEY_MIN, '1);
    send_op(OP_CLEAR, KEY_MAX, '1);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_op(op[OP_W-1:0], '1, '1);
  endtask

  task automatic test_insert_and_match();
    send_op(OP_INS_FRONT, KEY_MIN, 64'd0);
    send_op(OP_INS_BACK, KEY_MAX, '1);
    // duplicate key that stores the miss pattern itself
    send_op(OP_INS_BACK, KEY_MAX, MISS_PATTERN);
    send_op(OP_INS_FRONT, '1, 64'h5A5A_A5A5_0F0F_F0F0);
    send_op(OP_LOOKUP, KEY_MIN, '1);
    send_op(OP_LOOKUP, KEY_MAX, 64'd0);
    send_op(OP_LOOKUP, 32'd0, 64'd0);
    send_op(OP_DELETE, 32'd1, 64'd0);
    send_op(OP_SPARE_LAST, KEY_MAX, '1);
    send_op(OP_DELETE, KEY_MAX, 64'd0);
    send_op(OP_LOOKUP, KEY_MAX, 64'd0);
    send_op(OP_DELETE, KEY_MIN, 64'd0);
    send_op(OP_CLEAR, 32'd0, 64'd0);
    send_op(OP_LOOKUP, '1, 64'd0);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++)
      send_op((i % 2) ? OP_INS_BACK : OP_INS_FRONT, i, rand_value());
    send_op(OP_INS_FRONT, 32'd99, rand_value());
    send_op(OP_INS_BACK, 32'd99, rand_value());
    send_op(OP_LOOKUP, CAPACITY - 1, 64'd0);
    send_op(OP_DELETE, CAPACITY - 1, 64'd0);
    send_op(OP_DELETE, 32'd0, 64'd0);
    send_op(OP_INS_BACK, KEY_MIN, rand_value());
    send_op(OP_INS_FRONT, KEY_MAX, rand_value());
    send_op(OP_INS_BACK, 32'd5, rand_value());
    send_op(OP_LOOKUP, KEY_MIN, 64'd0);
    send_op(OP_SPARE_FIRST, 32'd5, rand_value());
    // hold off until the block has emptied its pipeline
    drain_results();
    send_op(OP_CLEAR, 32'd0, 64'd0);
  endtask

  task automatic test_random_ops(input int unsigned n);
    int               r;
    logic [OP_W-1:0]  op;
    for (int unsigned i = 0; i < n; i++) begin
      // one stretch with no idling on either side
      gaps_on   = !(i >= n / 3 && i < n / 3 + 60);
      stalls_on = gaps_on;
      if (i == n / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 24)      op = OP_INS_FRONT;
      else if (r < 48) op = OP_INS_BACK;
      else if (r < 70) op = OP_DELETE;
      else if (r < 95) op = OP_LOOKUP;
      else if (r < 97) op = OP_CLEAR;
      else             op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      send_op(op, pick_key(), rand_value());
    end
  endtask

  // result side: random stalls, mostly short
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result beat with nothing expected: %h", m_axis_tdata_o));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status)
          report_error($sformatf("result %0d status got %0d want %0d", results_checked,
                                 m_axis_tdata_o[1:0], want.status));
        if (m_axis_tdata_o[2] !== want.found)
          report_error($sformatf("result %0d found got %b want %b", results_checked,
                                 m_axis_tdata_o[2], want.found));
        if (m_axis_tdata_o[66:3] !== want.value)
          report_error($sformatf("result %0d value got %h want %h", results_checked,
                                 m_axis_tdata_o[66:3], want.value));
        if (m_axis_tdata_o[71:67] !== want.count)
          report_error($sformatf("result %0d count got %0d want %0d", results_checked,
                                 m_axis_tdata_o[71:67], want.count));
        results_checked++;
      end
    end
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_insert_and_match();
    test_full_list();
    test_random_ops(500);
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d operations and %0d checked results: empty, full and duplicate keys,",
             ops_sent, results_checked);
    $display("%0d rejected inserts, %0d key matches, spare codes, random stalls both sides",
             full_rejects, key_hits);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/okvl_pkg.sv
hw/rtl/okvl_cell.sv
hw/rtl/okvl_select.sv
hw/rtl/ordered_key_value_list.sv
test/ordered_key_value_list_tb.sv
